// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the glyph pixel generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond)
`endif
`endif

// ===== sv/gpg_pkg.sv =====
// Package of the glyph pixel generator: constants, register indexes and the font ROM.
`timescale 1ns / 1ps
package gpg_pkg;

  // Fixed field widths.
  localparam int POS_W       = 16;
  localparam int CODE_W      = 8;
  localparam int COLOR_W     = 32;
  localparam int PIX_IDX_W   = 20;
  localparam int CFG_DIM_W   = 11;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CELL_W      = 3;
  localparam int GLYPH_IDX_W = 7;
  localparam int NUM_GLYPHS  = 96;
  localparam int CELL        = 8;

  // Default screen limits for the top-level parameters.
  localparam int DEF_MAX_SCREEN_WIDTH  = 1024;
  localparam int DEF_MAX_SCREEN_HEIGHT = 1024;

  // Reset values of the configuration registers.
  localparam logic [CFG_DIM_W-1:0] RST_SCREEN_WIDTH  = 11'd640;
  localparam logic [CFG_DIM_W-1:0] RST_SCREEN_HEIGHT = 11'd480;

  // Character codes covered by the font.
  localparam logic [CODE_W-1:0] FIRST_CODE = 8'd32;
  localparam logic [CODE_W-1:0] LAST_CODE  = 8'd127;

  // Configuration register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SCREEN_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_SCREEN_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_ENABLED       = 2'd2;

  // 8x8 font, codes 32 to 127; row 0 is the top row, bit 0 the leftmost pixel.
  localparam logic [7:0] FONT_ROM [0:NUM_GLYPHS-1][0:CELL-1] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h18,8'h3C,8'h3C,8'h18,8'h18,8'h00,8'h18,8'h00},
    '{8'h36,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h36,8'h36,8'h7F,8'h36,8'h7F,8'h36,8'h36,8'h00},
    '{8'h0C,8'h3E,8'h03,8'h1E,8'h30,8'h1F,8'h0C,8'h00},
    '{8'h00,8'h63,8'h33,8'h18,8'h0C,8'h66,8'h63,8'h00},
    '{8'h1C,8'h36,8'h1C,8'h6E,8'h3B,8'h33,8'h6E,8'h00},
    '{8'h06,8'h06,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h18,8'h0C,8'h06,8'h06,8'h06,8'h0C,8'h18,8'h00},
    '{8'h06,8'h0C,8'h18,8'h18,8'h18,8'h0C,8'h06,8'h00},
    '{8'h00,8'h66,8'h3C,8'hFF,8'h3C,8'h66,8'h00,8'h00},
    '{8'h00,8'h0C,8'h0C,8'h3F,8'h0C,8'h0C,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h06},
    '{8'h00,8'h00,8'h00,8'h3F,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h0C,8'h0C,8'h00},
    '{8'h60,8'h30,8'h18,8'h0C,8'h06,8'h03,8'h01,8'h00},
    '{8'h3E,8'h63,8'h73,8'h7B,8'h6F,8'h67,8'h3E,8'h00},
    '{8'h0C,8'h0E,8'h0C,8'h0C,8'h0C,8'h0C,8'h3F,8'h00},
    '{8'h1E,8'h33,8'h30,8'h1C,8'h06,8'h33,8'h3F,8'h00},
    '{8'h1E,8'h33,8'h30,8'h1C,8'h30,8'h33,8'h1E,8'h00},
    '{8'h38,8'h3C,8'h36,8'h33,8'h7F,8'h30,8'h78,8'h00},
    '{8'h3F,8'h03,8'h1F,8'h30,8'h30,8'h33,8'h1E,8'h00},
    '{8'h1C,8'h06,8'h03,8'h1F,8'h33,8'h33,8'h1E,8'h00},
    '{8'h3F,8'h33,8'h30,8'h18,8'h0C,8'h0C,8'h0C,8'h00},
    '{8'h1E,8'h33,8'h33,8'h1E,8'h33,8'h33,8'h1E,8'h00},
    '{8'h1E,8'h33,8'h33,8'h3E,8'h30,8'h18,8'h0E,8'h00},
    '{8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h00},
    '{8'h00,8'h0C,8'h0C,8'h00,8'h00,8'h0C,8'h0C,8'h06},
    '{8'h18,8'h0C,8'h06,8'h03,8'h06,8'h0C,8'h18,8'h00},
    '{8'h00,8'h00,8'h3F,8'h00,8'h00,8'h3F,8'h00,8'h00},
    '{8'h06,8'h0C,8'h18,8'h30,8'h18,8'h0C,8'h06,8'h00},
    '{8'h1E,8'h33,8'h30,8'h18,8'h0C,8'h00,8'h0C,8'h00},
    '{8'h3E,8'h63,8'h7B,8'h7B,8'h7B,8'h03,8'h1E,8'h00},
    '{8'h0C,8'h1E,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h00},
    '{8'h3F,8'h66,8'h66,8'h3E,8'h66,8'h66,8'h3F,8'h00},
    '{8'h3C,8'h66,8'h03,8'h03,8'h03,8'h66,8'h3C,8'h00},
    '{8'h1F,8'h36,8'h66,8'h66,8'h66,8'h36,8'h1F,8'h00},
    '{8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h46,8'h7F,8'h00},
    '{8'h7F,8'h46,8'h16,8'h1E,8'h16,8'h06,8'h0F,8'h00},
    '{8'h3C,8'h66,8'h03,8'h03,8'h73,8'h66,8'h7C,8'h00},
    '{8'h33,8'h33,8'h33,8'h3F,8'h33,8'h33,8'h33,8'h00},
    '{8'h1E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
    '{8'h78,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E,8'h00},
    '{8'h67,8'h66,8'h36,8'h1E,8'h36,8'h66,8'h67,8'h00},
    '{8'h0F,8'h06,8'h06,8'h06,8'h46,8'h66,8'h7F,8'h00},
    '{8'h63,8'h77,8'h7F,8'h7F,8'h6B,8'h63,8'h63,8'h00},
    '{8'h63,8'h67,8'h6F,8'h7B,8'h73,8'h63,8'h63,8'h00},
    '{8'h1C,8'h36,8'h63,8'h63,8'h63,8'h36,8'h1C,8'h00},
    '{8'h3F,8'h66,8'h66,8'h3E,8'h06,8'h06,8'h0F,8'h00},
    '{8'h1E,8'h33,8'h33,8'h33,8'h3B,8'h1E,8'h38,8'h00},
    '{8'h3F,8'h66,8'h66,8'h3E,8'h36,8'h66,8'h67,8'h00},
    '{8'h1E,8'h33,8'h07,8'h0E,8'h38,8'h33,8'h1E,8'h00},
    '{8'h3F,8'h2D,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
    '{8'h33,8'h33,8'h33,8'h33,8'h33,8'h33,8'h3F,8'h00},
    '{8'h33,8'h33,8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h00},
    '{8'h63,8'h63,8'h63,8'h6B,8'h7F,8'h77,8'h63,8'h00},
    '{8'h63,8'h63,8'h36,8'h1C,8'h1C,8'h36,8'h63,8'h00},
    '{8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h0C,8'h1E,8'h00},
    '{8'h7F,8'h63,8'h31,8'h18,8'h4C,8'h66,8'h7F,8'h00},
    '{8'h1E,8'h06,8'h06,8'h06,8'h06,8'h06,8'h1E,8'h00},
    '{8'h03,8'h06,8'h0C,8'h18,8'h30,8'h60,8'h40,8'h00},
    '{8'h1E,8'h18,8'h18,8'h18,8'h18,8'h18,8'h1E,8'h00},
    '{8'h08,8'h1C,8'h36,8'h63,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hFF},
    '{8'h0C,8'h0C,8'h18,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h1E,8'h30,8'h3E,8'h33,8'h6E,8'h00},
    '{8'h07,8'h06,8'h06,8'h3E,8'h66,8'h66,8'h3B,8'h00},
    '{8'h00,8'h00,8'h1E,8'h33,8'h03,8'h33,8'h1E,8'h00},
    '{8'h38,8'h30,8'h30,8'h3E,8'h33,8'h33,8'h6E,8'h00},
    '{8'h00,8'h00,8'h1E,8'h33,8'h3F,8'h03,8'h1E,8'h00},
    '{8'h1C,8'h36,8'h06,8'h0F,8'h06,8'h06,8'h0F,8'h00},
    '{8'h00,8'h00,8'h6E,8'h33,8'h33,8'h3E,8'h30,8'h1F},
    '{8'h07,8'h06,8'h36,8'h6E,8'h66,8'h66,8'h67,8'h00},
    '{8'h0C,8'h00,8'h0E,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
    '{8'h30,8'h00,8'h30,8'h30,8'h30,8'h33,8'h33,8'h1E},
    '{8'h07,8'h06,8'h66,8'h36,8'h1E,8'h36,8'h67,8'h00},
    '{8'h0E,8'h0C,8'h0C,8'h0C,8'h0C,8'h0C,8'h1E,8'h00},
    '{8'h00,8'h00,8'h33,8'h7F,8'h7F,8'h6B,8'h63,8'h00},
    '{8'h00,8'h00,8'h1F,8'h33,8'h33,8'h33,8'h33,8'h00},
    '{8'h00,8'h00,8'h1E,8'h33,8'h33,8'h33,8'h1E,8'h00},
    '{8'h00,8'h00,8'h3B,8'h66,8'h66,8'h3E,8'h06,8'h0F},
    '{8'h00,8'h00,8'h6E,8'h33,8'h33,8'h3E,8'h30,8'h78},
    '{8'h00,8'h00,8'h3B,8'h6E,8'h66,8'h06,8'h0F,8'h00},
    '{8'h00,8'h00,8'h3E,8'h03,8'h1E,8'h30,8'h1F,8'h00},
    '{8'h08,8'h0C,8'h3E,8'h0C,8'h0C,8'h2C,8'h18,8'h00},
    '{8'h00,8'h00,8'h33,8'h33,8'h33,8'h33,8'h6E,8'h00},
    '{8'h00,8'h00,8'h33,8'h33,8'h33,8'h1E,8'h0C,8'h00},
    '{8'h00,8'h00,8'h63,8'h6B,8'h7F,8'h7F,8'h36,8'h00},
    '{8'h00,8'h00,8'h63,8'h36,8'h1C,8'h36,8'h63,8'h00},
    '{8'h00,8'h00,8'h33,8'h33,8'h33,8'h3E,8'h30,8'h1F},
    '{8'h00,8'h00,8'h3F,8'h19,8'h0C,8'h26,8'h3F,8'h00},
    '{8'h38,8'h0C,8'h0C,8'h07,8'h0C,8'h0C,8'h38,8'h00},
    '{8'h18,8'h18,8'h18,8'h00,8'h18,8'h18,8'h18,8'h00},
    '{8'h07,8'h0C,8'h0C,8'h38,8'h0C,8'h0C,8'h07,8'h00},
    '{8'h6E,8'h3B,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
    '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}
  };

endpackage

// ===== sv/glyph_pixel_generator_unit.sv =====
// Top level of the glyph pixel generator: clipping, pixel sequencer and output register.
// The first pixel beat of a character passes the input stage, the pixel sequencer and the output register.
// Throughput: one pixel beat per cycle while out_ready is high; a character gives one beat per
// visible pixel (64 for a cell fully on screen), all from the single pixel sequencer. A character that
// draws nothing (disabled, or cell off screen) leaves the input stage without waiting for the sequencer.
// Reset (synchronous, active low): width 640, height 480, output disabled, pipeline empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glyph_pixel_generator_unit
  import gpg_pkg::*;
#(
  parameter int MAX_SCREEN_WIDTH  = DEF_MAX_SCREEN_WIDTH,
  parameter int MAX_SCREEN_HEIGHT = DEF_MAX_SCREEN_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Character request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [POS_W-1:0]      in_pos_x,
  input  logic [POS_W-1:0]      in_pos_y,
  input  logic [CODE_W-1:0]     in_char_code,
  input  logic [COLOR_W-1:0]    in_fg_color,
  input  logic [COLOR_W-1:0]    in_bg_color,
  // Pixel write channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_IDX_W-1:0]  out_pixel_index,
  output logic [COLOR_W-1:0]    out_pixel_value,
  output logic                  out_last_pixel
);

  localparam int WW = $clog2(MAX_SCREEN_WIDTH + 1);
  localparam int HW = $clog2(MAX_SCREEN_HEIGHT + 1);
  localparam int XW = $clog2(MAX_SCREEN_WIDTH);
  localparam int YW = $clog2(MAX_SCREEN_HEIGHT);
  localparam int SW = POS_W + 2;

  // Configuration registers.
  logic [CFG_DIM_W-1:0] screen_width_r, screen_height_r;
  logic                 enabled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= RST_SCREEN_WIDTH;
      screen_height_r <= RST_SCREEN_HEIGHT;
      enabled_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata[CFG_DIM_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[CFG_DIM_W-1:0];
        CFG_ENABLED:       enabled_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Screen size clamped to the maximum set by the MAX_SCREEN parameters.
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  assign w_eff = (32'(screen_width_r) > MAX_SCREEN_WIDTH) ? WW'(MAX_SCREEN_WIDTH)
                                                          : WW'(screen_width_r);
  assign h_eff = (32'(screen_height_r) > MAX_SCREEN_HEIGHT) ? HW'(MAX_SCREEN_HEIGHT)
                                                            : HW'(screen_height_r);

  // Handshake signals between the stages.
  logic s1_valid_r, s1_take, s1_vis;
  logic seq_valid_r, seq_adv, seq_fin, seq_load, seq_at_row_end, seq_at_end;
  logic out_valid_r, out_free;

  // Input stage registers.
  logic [POS_W-1:0]   s1_pos_x_r, s1_pos_y_r;
  logic [CODE_W-1:0]  s1_char_code_r;
  logic [COLOR_W-1:0] s1_fg_color_r, s1_bg_color_r;

  assign in_ready = !s1_valid_r || s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pos_x_r     <= in_pos_x;
      s1_pos_y_r     <= in_pos_y;
      s1_char_code_r <= in_char_code;
      s1_fg_color_r  <= in_fg_color;
      s1_bg_color_r  <= in_bg_color;
    end
  end

  // Clipping of the cell against the screen.
  logic signed [SW-1:0] xs, ys, ws, hs, dx, dy;
  logic [CELL_W-1:0]    col_lo, col_hi, row_lo, row_hi;
  logic [XW-1:0]        px0;
  logic [YW-1:0]        py0;
  logic [GLYPH_IDX_W-1:0] glyph_idx;
  logic [YW+WW-1:0]     row_prod;
  logic [PIX_IDX_W-1:0] start_idx;

  always_comb begin
    xs = {{2{s1_pos_x_r[POS_W-1]}}, s1_pos_x_r};
    ys = {{2{s1_pos_y_r[POS_W-1]}}, s1_pos_y_r};
    ws = signed'(SW'(w_eff));
    hs = signed'(SW'(h_eff));
    dx = ws - SW'(1) - xs;
    dy = hs - SW'(1) - ys;
    s1_vis = enabled_r && (w_eff != '0) && (h_eff != '0) &&
             (xs > -SW'(CELL)) && (ys > -SW'(CELL)) && (xs < ws) && (ys < hs);
    col_lo = xs[SW-1] ? CELL_W'(3'd0 - s1_pos_x_r[CELL_W-1:0]) : '0;
    row_lo = ys[SW-1] ? CELL_W'(3'd0 - s1_pos_y_r[CELL_W-1:0]) : '0;
    col_hi = (dx > SW'(CELL - 1)) ? CELL_W'(CELL - 1) : dx[CELL_W-1:0];
    row_hi = (dy > SW'(CELL - 1)) ? CELL_W'(CELL - 1) : dy[CELL_W-1:0];
    px0 = xs[SW-1] ? '0 : s1_pos_x_r[XW-1:0];
    py0 = ys[SW-1] ? '0 : s1_pos_y_r[YW-1:0];
    // Codes outside the font draw as a space, which is glyph 0.
    glyph_idx = (s1_char_code_r inside {[FIRST_CODE:LAST_CODE]}) ?
                GLYPH_IDX_W'(s1_char_code_r - FIRST_CODE) : '0;
    row_prod  = YW'(py0) * WW'(w_eff);
    start_idx = PIX_IDX_W'(row_prod) + PIX_IDX_W'(px0);
  end

  // Stage handshakes: invisible cells are dropped in the input stage.
  assign out_free = !out_valid_r || out_ready;
  assign seq_adv  = seq_valid_r && out_free;
  assign seq_fin  = seq_adv && seq_at_end;
  assign s1_take  = s1_valid_r && (!s1_vis || !seq_valid_r || seq_fin);
  assign seq_load = s1_take && s1_vis;

  // Pixel sequencer registers.
  logic [CELL_W-1:0]      seq_i_r, seq_j_r, seq_col_lo_r, seq_col_hi_r, seq_row_hi_r;
  logic [CELL_W-1:0]      seq_i_nxt, seq_j_nxt;
  logic [GLYPH_IDX_W-1:0] seq_glyph_r;
  logic [COLOR_W-1:0]     seq_fg_r, seq_bg_r;
  logic [PIX_IDX_W-1:0]   seq_idx_r, seq_row_idx_r, seq_idx_nxt, seq_row_idx_nxt;
  logic                   seq_valid_nxt;
  logic [7:0]             glyph_row;

  assign seq_at_row_end = (seq_i_r == seq_col_hi_r);
  assign seq_at_end     = seq_at_row_end && (seq_j_r == seq_row_hi_r);
  assign glyph_row      = FONT_ROM[seq_glyph_r][seq_j_r];

  // Walk the visible window row by row, left to right.
  always_comb begin
    seq_valid_nxt   = seq_valid_r;
    seq_i_nxt       = seq_i_r;
    seq_j_nxt       = seq_j_r;
    seq_idx_nxt     = seq_idx_r;
    seq_row_idx_nxt = seq_row_idx_r;
    if (seq_load) begin
      seq_valid_nxt   = 1'b1;
      seq_i_nxt       = col_lo;
      seq_j_nxt       = row_lo;
      seq_idx_nxt     = start_idx;
      seq_row_idx_nxt = start_idx;
    end else if (seq_fin) begin
      seq_valid_nxt = 1'b0;
    end else if (seq_adv) begin
      if (seq_at_row_end) begin
        seq_i_nxt       = seq_col_lo_r;
        seq_j_nxt       = seq_j_r + 1'b1;
        seq_row_idx_nxt = seq_row_idx_r + PIX_IDX_W'(w_eff);
        seq_idx_nxt     = seq_row_idx_r + PIX_IDX_W'(w_eff);
      end else begin
        seq_i_nxt   = seq_i_r + 1'b1;
        seq_idx_nxt = seq_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_valid_r <= 1'b0;
    end else begin
      seq_valid_r <= seq_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_i_r       <= seq_i_nxt;
    seq_j_r       <= seq_j_nxt;
    seq_idx_r     <= seq_idx_nxt;
    seq_row_idx_r <= seq_row_idx_nxt;
    if (seq_load) begin
      seq_col_lo_r <= col_lo;
      seq_col_hi_r <= col_hi;
      seq_row_hi_r <= row_hi;
      seq_glyph_r  <= glyph_idx;
      seq_fg_r     <= s1_fg_color_r;
      seq_bg_r     <= s1_bg_color_r;
    end
  end

  // Output register; it takes a new beat whenever it is empty or the current one leaves.
  logic [PIX_IDX_W-1:0] out_pixel_index_r;
  logic [COLOR_W-1:0]   out_pixel_value_r;
  logic                 out_last_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= seq_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_adv) begin
      out_pixel_index_r <= seq_idx_r;
      out_pixel_value_r <= glyph_row[seq_i_r] ? seq_fg_r : seq_bg_r;
      out_last_pixel_r  <= seq_at_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_pixel_index_r;
  assign out_pixel_value = out_pixel_value_r;
  assign out_last_pixel  = out_last_pixel_r;

  // The sequencer never leaves the visible window of its cell.
  `ASSERT_PROP(a_seq_in_window, clk, rst_n,
               seq_valid_r |-> (seq_i_r >= seq_col_lo_r && seq_i_r <= seq_col_hi_r &&
                                seq_j_r <= seq_row_hi_r))
  // The final pixel of a cell lands in the output register flagged as last.
  `ASSERT_PROP(a_fin_marks_last, clk, rst_n, seq_fin |=> (out_valid_r && out_last_pixel_r))
  // A new cell is only loaded when the sequencer is free or finishing.
  `ASSERT_NEVER(a_load_while_busy, clk, rst_n, seq_load && seq_valid_r && !seq_fin)

endmodule

// ===== test/glyph_pixel_generator_unit_tb.sv =====
// Self-checking testbench of the glyph pixel generator: directed and random character beats.
`timescale 1ns / 1ps

module glyph_pixel_generator_unit_tb;
  import gpg_pkg::*;

  // Run limits and idle lengths.
  localparam int LIMIT_CYCLES     = 3000000;
  localparam int SETTLE_CYCLES    = 10;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int MAX_REPORTS      = 40;
  localparam int RANDOM_PER_PHASE = 39;
  localparam logic [CODE_W-1:0] SPACE_CODE = 8'h20;

  // Screen sizes visited by the random part, including the oversized extreme.
  localparam int RAND_WIDTHS  [7] = '{640, 8, 1024, 2047, 13, 1, 100};
  localparam int RAND_HEIGHTS [7] = '{480, 8, 1024, 2047, 5, 3, 1};

  typedef struct packed {
    logic [PIX_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   value;
    logic                 last;
  } pixel_write_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SCREEN_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [POS_W-1:0]      in_pos_x = '0;
  logic [POS_W-1:0]      in_pos_y = '0;
  logic [CODE_W-1:0]     in_char_code = '0;
  logic [COLOR_W-1:0]    in_fg_color = '0;
  logic [COLOR_W-1:0]    in_bg_color = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_IDX_W-1:0]  out_pixel_index;
  logic [COLOR_W-1:0]    out_pixel_value;
  logic                  out_last_pixel;

  // Shadow copy of the configuration registers, as the block holds them.
  logic [CFG_DIM_W-1:0] shadow_width   = RST_SCREEN_WIDTH;
  logic [CFG_DIM_W-1:0] shadow_height  = RST_SCREEN_HEIGHT;
  logic                 shadow_enabled = 1'b0;

  pixel_write_t expected_writes [$];
  int  error_count = 0;
  int  pixel_beats = 0;
  int  cycle_count = 0;
  logic steady_phase = 1'b0;
  logic long_hold_pending = 1'b0;

  glyph_pixel_generator_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_char_code   (in_char_code),
    .in_fg_color    (in_fg_color),
    .in_bg_color    (in_bg_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_index(out_pixel_index),
    .out_pixel_value(out_pixel_value),
    .out_last_pixel (out_last_pixel)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Queues the pixel writes that one character beat should produce, in row-major order.
  function automatic void predict_glyph_writes(input logic [POS_W-1:0] pos_x,
                                               input logic [POS_W-1:0] pos_y,
                                               input logic [CODE_W-1:0] code,
                                               input logic [COLOR_W-1:0] fg,
                                               input logic [COLOR_W-1:0] bg);
    int x0, y0, w, h, row, col, px, py, drawn;
    logic [CODE_W-1:0] glyph_code;
    logic [7:0] bits;
    pixel_write_t pw;
    x0 = int'($signed(pos_x));
    y0 = int'($signed(pos_y));
    w = (shadow_width > DEF_MAX_SCREEN_WIDTH) ? DEF_MAX_SCREEN_WIDTH : int'(shadow_width);
    h = (shadow_height > DEF_MAX_SCREEN_HEIGHT) ? DEF_MAX_SCREEN_HEIGHT : int'(shadow_height);
    drawn = 0;
    if (!shadow_enabled) return;
    if (x0 + CELL <= 0 || y0 + CELL <= 0 || x0 >= w || y0 >= h) return;
    // Codes outside the font draw as a space.
    glyph_code = (code < FIRST_CODE || code > LAST_CODE) ? SPACE_CODE : code;
    for (row = 0; row < CELL; row++) begin
      py = y0 + row;
      if (py < 0 || py >= h) continue;
      bits = FONT_ROM[glyph_code - FIRST_CODE][row];
      for (col = 0; col < CELL; col++) begin
        px = x0 + col;
        if (px < 0 || px >= w) continue;
        pw.index = PIX_IDX_W'(py * w + px);
        pw.value = bits[col] ? fg : bg;
        pw.last  = 1'b0;
        expected_writes.push_back(pw);
        drawn++;
      end
    end
    if (drawn > 0) expected_writes[expected_writes.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("ERROR pixel beat %0d: %s expected 0x%0h, got 0x%0h",
               pixel_beats, what, want, got);
  endtask

  // Compare every accepted pixel beat with the oldest queued write.
  always @(posedge clk) begin
    pixel_write_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        report_mismatch("unexpected write, index", '0, 32'(out_pixel_index));
      end else begin
        want = expected_writes.pop_front();
        if (out_pixel_index !== want.index)
          report_mismatch("pixel_index", 32'(want.index), 32'(out_pixel_index));
        if (out_pixel_value !== want.value)
          report_mismatch("pixel_value", want.value, out_pixel_value);
        if (out_last_pixel !== want.last)
          report_mismatch("last_pixel", 32'(want.last), 32'(out_last_pixel));
      end
      pixel_beats++;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 30);
  endfunction

  // Pixel receiver: random stalls, a requested long hold, or none in a steady phase.
  initial begin
    int stall, run;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        stall = LONG_HOLD_CYCLES;
      end else if (steady_phase) begin
        stall = 0;
      end else begin
        stall = pick_stall();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      run = $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  // Offers one character beat after a random gap (none in a steady phase) and predicts its writes once taken.
  // Valid is left high so that a back-to-back beat follows without a dip.
  task automatic send_char(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                           input logic [CODE_W-1:0] code, input logic [COLOR_W-1:0] fg,
                           input logic [COLOR_W-1:0] bg);
    int gap;
    gap = steady_phase ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pos_x     <= x;
    in_pos_y     <= y;
    in_char_code <= code;
    in_fg_color  <= fg;
    in_bg_color  <= bg;
    do @(posedge clk); while (!in_ready);
    predict_glyph_writes(x, y, code, fg, bg);
  endtask

  // Stop offering, wait for every queued write, then let silent beats leave the block.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers while the block is idle.
  task automatic set_screen(input logic [CFG_DIM_W-1:0] width,
                            input logic [CFG_DIM_W-1:0] height, input logic en);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_wdata <= height;
    @(posedge clk);
    cfg_index <= CFG_ENABLED;
    cfg_wdata <= CFG_DATA_W'(en);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_width   = width;
    shadow_height  = height;
    shadow_enabled = en;
  endtask

  // Random coordinate: mostly inside the screen, some at the edges, some anywhere.
  function automatic int near_coord(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return int'($signed(16'($urandom)));
    if (r < 25) return int'($urandom_range(0, 16)) - 8;
    if (r < 40) return span + int'($urandom_range(0, 16)) - 9;
    return int'($urandom_range(0, (span > 8) ? span - 8 : 0));
  endfunction

  function automatic logic [CODE_W-1:0] random_code();
    if ($urandom_range(0, 99) < 80) return CODE_W'($urandom_range(32, 127));
    return CODE_W'($urandom_range(0, 255));
  endfunction

  // The block comes out of reset disabled: nothing may be written.
  task automatic test_disabled_after_reset();
    send_char(0, 0, "A", 32'hFFFF_FFFF, 32'h0);
    send_char(100, 50, "Z", 32'h1234_5678, 32'h8765_4321);
    send_char(-3, -3, 8'd200, 32'h0, 32'hFFFF_FFFF);
    send_char(632, 472, 8'd127, 32'hAAAA_AAAA, 32'h5555_5555);
    wait_for_drain();
  endtask

  // Clipping on every side, unknown and blank codes, extremes of position and color.
  task automatic test_directed_glyphs();
    set_screen(11'd640, 11'd480, 1'b1);
    send_char(0, 0, "A", 32'hFFFF_FFFF, 32'h0);
    send_char(632, 472, "~", 32'h0, 32'hFFFF_FFFF);
    send_char(-3, 10, "M", 32'hFFFF_FFFF, 32'h0);
    send_char(636, 20, "W", 32'h0, 32'hFFFF_FFFF);
    send_char(30, -5, "g", 32'hFFFF_FFFF, 32'h0);
    send_char(40, 476, "j", 32'h0, 32'hFFFF_FFFF);
    send_char(-7, -7, "#", 32'hFFFF_FFFF, 32'h0);
    send_char(639, 479, "@", 32'hFFFF_FFFF, 32'h0);
    send_char(100, 100, 8'd0, 32'hFFFF_FFFF, 32'h0);
    send_char(108, 100, 8'd31, 32'hFFFF_FFFF, 32'h0);
    send_char(116, 100, 8'd128, 32'hFFFF_FFFF, 32'h0);
    send_char(124, 100, 8'd255, 32'hFFFF_FFFF, 32'h0);
    send_char(132, 100, 8'd127, 32'hFFFF_FFFF, 32'h0);
    send_char(140, 100, 8'd32, 32'hFFFF_FFFF, 32'h0);
    send_char(-8, 0, "A", 32'hFFFF_FFFF, 32'h0);
    send_char(640, 0, "A", 32'hFFFF_FFFF, 32'h0);
    send_char(0, -8, "A", 32'hFFFF_FFFF, 32'h0);
    send_char(0, 480, "A", 32'hFFFF_FFFF, 32'h0);
    send_char(-32768, -32768, "B", 32'hFFFF_FFFF, 32'h0);
    send_char(32767, 32767, "B", 32'hFFFF_FFFF, 32'h0);
    send_char(-32768, 100, "C", 32'hFFFF_FFFF, 32'h0);
    send_char(100, 32767, "C", 32'hFFFF_FFFF, 32'h0);
    send_char(200, 200, "Z", 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    wait_for_drain();
  endtask

  // Zero, one-pixel, maximum and oversized screen dimensions.
  task automatic test_screen_extremes();
    set_screen(11'd0, 11'd480, 1'b1);
    send_char(0, 0, "A", 32'hFFFF_FFFF, 32'h0);
    send_char(5, 5, "B", 32'hFFFF_FFFF, 32'h0);
    set_screen(11'd640, 11'd0, 1'b1);
    send_char(0, 0, "A", 32'hFFFF_FFFF, 32'h0);
    set_screen(11'd1, 11'd1, 1'b1);
    send_char(0, 0, "A", 32'hFFFF_FFFF, 32'h0);
    send_char(-7, -7, "#", 32'hFFFF_FFFF, 32'h0);
    send_char(-3, 0, "H", 32'h0, 32'hFFFF_FFFF);
    set_screen(11'd2047, 11'd2047, 1'b1);
    send_char(1016, 1016, "A", 32'hFFFF_FFFF, 32'h0);
    send_char(1020, 1020, "B", 32'hFFFF_FFFF, 32'h0);
    send_char(1024, 0, "C", 32'hFFFF_FFFF, 32'h0);
    send_char(0, 1023, "D", 32'hFFFF_FFFF, 32'h0);
    set_screen(11'd1024, 11'd1024, 1'b1);
    send_char(1016, 1016, "@", 32'hFFFF_FFFF, 32'h0);
    send_char(1023, 1023, "X", 32'hFFFF_FFFF, 32'h0);
    wait_for_drain();
  endtask

  // The receiver holds off while characters keep coming, so the block must stall its input.
  task automatic test_output_backpressure();
    int k;
    set_screen(11'd640, 11'd480, 1'b1);
    steady_phase = 1'b1;
    long_hold_pending = 1'b1;
    for (k = 0; k < 12; k++)
      send_char(16'(8 * k), 16'd16, CODE_W'(8'd65 + k), $urandom, $urandom);
    steady_phase = 1'b0;
    wait_for_drain();
  endtask

  // Back-to-back beats with no idling on either side.
  task automatic test_steady_stream();
    int k;
    set_screen(11'd320, 11'd200, 1'b1);
    steady_phase = 1'b1;
    for (k = 0; k < 20; k++)
      send_char(16'(near_coord(320)), 16'(near_coord(200)), random_code(), $urandom, $urandom);
    wait_for_drain();
    steady_phase = 1'b0;
  endtask

  // Random characters over several screen sizes, with one disabled phase between them.
  task automatic test_random_chars();
    int p, k, w_eff, h_eff;
    for (p = 0; p < 7; p++) begin
      set_screen(CFG_DIM_W'(RAND_WIDTHS[p]), CFG_DIM_W'(RAND_HEIGHTS[p]), 1'b1);
      w_eff = (RAND_WIDTHS[p] > DEF_MAX_SCREEN_WIDTH) ? DEF_MAX_SCREEN_WIDTH : RAND_WIDTHS[p];
      h_eff = (RAND_HEIGHTS[p] > DEF_MAX_SCREEN_HEIGHT) ? DEF_MAX_SCREEN_HEIGHT
                                                        : RAND_HEIGHTS[p];
      for (k = 0; k < RANDOM_PER_PHASE; k++)
        send_char(16'(near_coord(w_eff)), 16'(near_coord(h_eff)), random_code(),
                  $urandom, $urandom);
      if (p == 2) begin
        set_screen(CFG_DIM_W'(RAND_WIDTHS[p]), CFG_DIM_W'(RAND_HEIGHTS[p]), 1'b0);
        for (k = 0; k < 6; k++)
          send_char(16'(near_coord(w_eff)), 16'(near_coord(h_eff)), random_code(),
                    $urandom, $urandom);
      end
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled_after_reset();
    test_directed_glyphs();
    test_screen_extremes();
    test_output_backpressure();
    test_steady_stream();
    test_random_chars();
    wait_for_drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
